[rtl/llmq_pkg.sv]
package llmq_pkg;

  localparam int OP_W   = 2;
  localparam int QID_W  = 2;
  localparam int CELL_W = 8;
  localparam int CFG_W  = 9;

  localparam logic [CFG_W-1:0] CELLS_IN_USE_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REINIT  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

endpackage

[rtl/llmq_link_ram.sv]
module llmq_link_ram
  #(
    parameter int NUM_CELLS = 256,
    localparam int AW = $clog2(NUM_CELLS),
    localparam int LW = $clog2(NUM_CELLS + 1)
  )
  (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [LW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [LW-1:0] rdata
  );

  logic [LW-1:0] mem [NUM_CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/llmq_ctrl.sv]
module llmq_ctrl
  import llmq_pkg::*;
  #(
    parameter int NUM_CELLS  = 256,
    parameter int NUM_QUEUES = 4,
    parameter int POOL_QUEUE = 3,
    localparam int AW = $clog2(NUM_CELLS),
    localparam int LW = $clog2(NUM_CELLS + 1)
  )
  (
    input  logic              clk,
    input  logic              rst,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [QID_W-1:0]  queue_id,
    input  logic [CELL_W-1:0] cell_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              got_cell,
    output logic [CELL_W-1:0] popped_cell,
    input  logic [CFG_W-1:0]  cells_in_use,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [LW-1:0]     mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  logic [LW-1:0]     mem_rdata
  );

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam bit HAS_FREE = (POOL_QUEUE < NUM_QUEUES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEQ,
    ST_WALK,
    ST_HOLD
  } state_t;

  state_t state;
  state_t state_next;

  logic [LW-1:0] head_link [NUM_QUEUES];
  logic [LW-1:0] tail_link [NUM_QUEUES];

  logic [AW-1:0]     clr_idx;
  logic [AW-1:0]     walk_idx;
  logic [LW-1:0]     walk_n;
  logic [QW-1:0]     deq_q;
  logic [AW-1:0]     deq_cell;
  logic              pend_got;
  logic [CELL_W-1:0] pend_cell;

  logic [QW-1:0]     qsel;
  logic              q_ok;
  logic              c_ok;
  logic [LW-1:0]     h_cur;
  logic [LW-1:0]     t_cur;
  logic              h_ok;
  logic              t_ok;
  logic [LW-1:0]     in_link;
  logic [CW-1:0]     cfg_ext;
  logic [LW-1:0]     n_sat;
  logic              walk_last;
  logic              out_free;
  logic              res_valid;
  logic              res_got;
  logic [CELL_W-1:0] res_cell;

  assign qsel     = QW'(queue_id);
  assign q_ok     = (32'(queue_id) < NUM_QUEUES);
  assign c_ok     = (32'(cell_index) < NUM_CELLS);
  assign h_cur    = head_link[qsel];
  assign t_cur    = tail_link[qsel];
  assign h_ok     = (h_cur != '0) && (h_cur <= LW'(NUM_CELLS));
  assign t_ok     = (t_cur != '0) && (t_cur <= LW'(NUM_CELLS));
  assign in_link  = LW'(cell_index) + LW'(1);
  assign cfg_ext  = CW'(cells_in_use);
  assign n_sat    = (cfg_ext > CW'(NUM_CELLS)) ? LW'(NUM_CELLS) : LW'(cfg_ext);
  assign walk_last = ((LW'(walk_idx) + LW'(1)) == walk_n);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = AW'(h_cur - LW'(1));
    res_valid  = 1'b0;
    res_got    = 1'b0;
    res_cell   = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        if (clr_idx == AW'(NUM_CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(operation))
            OP_ENQUEUE: begin
              // link the previous tail to the new cell
              if (q_ok && c_ok && t_ok) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(t_cur - LW'(1));
                mem_wdata = in_link;
              end
              res_valid = 1'b1;
            end
            OP_DEQUEUE: begin
              if (q_ok && h_ok) begin
                state_next = ST_DEQ;
              end else begin
                res_valid = 1'b1;
              end
            end
            OP_REINIT: begin
              if (HAS_FREE && (n_sat != '0)) begin
                state_next = ST_WALK;
              end else begin
                res_valid = 1'b1;
              end
            end
            OP_NOP: begin
              res_valid = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_DEQ: begin
        mem_we    = 1'b1;
        mem_waddr = deq_cell;
        res_valid = 1'b1;
        res_got   = 1'b1;
        res_cell  = CELL_W'(deq_cell);
      end
      ST_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = walk_idx;
        mem_wdata = walk_last ? '0 : (LW'(walk_idx) + LW'(2));
        res_valid = walk_last;
      end
      ST_HOLD: begin
        res_valid = 1'b1;
        res_got   = pend_got;
        res_cell  = pend_cell;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (res_valid) begin
      state_next = out_free ? ST_IDLE : ST_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_link[q] <= '0;
        tail_link[q] <= '0;
      end
    end else begin
      state <= state_next;

      if (res_valid && out_free) begin
        out_valid   <= 1'b1;
        got_cell    <= res_got;
        popped_cell <= res_cell;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (res_valid && !out_free) begin
        pend_got  <= res_got;
        pend_cell <= res_cell;
      end

      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
        end
        ST_IDLE: begin
          deq_q    <= qsel;
          deq_cell <= AW'(h_cur - LW'(1));
          walk_idx <= '0;
          walk_n   <= n_sat;
          if (in_valid) begin
            case (op_t'(operation))
              OP_ENQUEUE: begin
                if (q_ok && c_ok) begin
                  tail_link[qsel] <= in_link;
                  if (t_cur == '0) begin
                    head_link[qsel] <= in_link;
                  end
                end
              end
              OP_DEQUEUE: begin
                // head points past the pool: drop the queue
                if (q_ok && (h_cur != '0) && !h_ok) begin
                  head_link[qsel] <= '0;
                  tail_link[qsel] <= '0;
                end
              end
              OP_REINIT: begin
                for (int q = 0; q < NUM_QUEUES; q++) begin
                  if (HAS_FREE && (q == POOL_QUEUE) && (n_sat != '0)) begin
                    head_link[q] <= LW'(1);
                    tail_link[q] <= n_sat;
                  end else begin
                    head_link[q] <= '0;
                    tail_link[q] <= '0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DEQ: begin
          if (mem_rdata != '0) begin
            head_link[deq_q] <= mem_rdata;
          end else begin
            head_link[deq_q] <= '0;
            tail_link[deq_q] <= '0;
          end
        end
        ST_WALK: begin
          walk_idx <= walk_idx + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/linked_list_multi_queue.sv]
// Linked-list queue manager: NUM_QUEUES FIFO queues threaded through a pool of
// NUM_CELLS cells by a one-port-write, one-port-read link memory. One item is
// in flight at a time. Enqueue and unused or out-of-range operations give their
// result straight from idle; dequeue first passes through a read state, since
// the link memory read is registered; reinitialize walks the chained cells
// (min(cells_in_use, NUM_CELLS)) in its walk state, writing one link per cycle.
// After reset the block clears all NUM_CELLS cells of the link memory and holds
// in_stall high meanwhile; the cells_in_use register may be written then. A
// result sits in an output register, so a new item may be taken while it waits;
// if a second result is ready before the first transfers, the block holds.
module linked_list_multi_queue
  import llmq_pkg::*;
  #(
    parameter int NUM_CELLS  = 256,
    parameter int NUM_QUEUES = 4,
    parameter int POOL_QUEUE = 3
  )
  (
    input  logic              clk,
    input  logic              rst,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [QID_W-1:0]  queue_id,
    input  logic [CELL_W-1:0] cell_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              got_cell,
    output logic [CELL_W-1:0] popped_cell,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_data
  );

  localparam int AW = $clog2(NUM_CELLS);
  localparam int LW = $clog2(NUM_CELLS + 1);

  logic [CFG_W-1:0] cells_in_use;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [LW-1:0]    mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [LW-1:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_use <= CELLS_IN_USE_RESET;
    end else if (cfg_we) begin
      cells_in_use <= cfg_data;
    end
  end

  llmq_ctrl #(
    .NUM_CELLS  (NUM_CELLS),
    .NUM_QUEUES (NUM_QUEUES),
    .POOL_QUEUE (POOL_QUEUE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .queue_id     (queue_id),
    .cell_index   (cell_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .got_cell     (got_cell),
    .popped_cell  (popped_cell),
    .cells_in_use (cells_in_use),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  llmq_link_ram #(
    .NUM_CELLS (NUM_CELLS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[rtl/llmq_checker.sv]
module llmq_checker
  import llmq_pkg::*;
  (
    input logic              clk,
    input logic              rst,
    input logic              in_valid,
    input logic              in_stall,
    input logic [OP_W-1:0]   operation,
    input logic              out_valid,
    input logic              out_stall,
    input logic              got_cell,
    input logic [CELL_W-1:0] popped_cell
  );

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(got_cell) && $stable(popped_cell))
    else $error("result changed while stalled");

  // an empty result carries a zero cell
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !got_cell |-> popped_cell == '0)
    else $error("popped_cell nonzero without got_cell");

  // link memory clear follows reset
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken right after reset");

  // enqueue transfer with a free output yields an empty result next cycle
  a_enq_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && (operation == OP_ENQUEUE)
      |=> out_valid && !got_cell)
    else $error("enqueue result missing");

endmodule

bind linked_list_multi_queue llmq_checker u_llmq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .operation   (operation),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .got_cell    (got_cell),
  .popped_cell (popped_cell)
);
